>>> rtl/wphf_pkg.sv
// ----------------------------------------------------------------------------
// wphf_pkg
// Shared types, constants and the arctangent table of the waypoint follower.
// ----------------------------------------------------------------------------
package wphf_pkg;

  localparam int unsigned MAX_WAYPOINTS_DEF   = 128;
  localparam int unsigned ATAN_ITERATIONS_DEF = 16;

  // Widths fixed by the item fields.
  localparam int unsigned COORD_W = 24;
  localparam int unsigned CORDIC_W = 28;
  localparam int unsigned ITER_W = 5;
  localparam int unsigned ERR_W = 18;

  localparam logic signed [ERR_W-1:0] PI_Q13 = 18'sd25736;
  localparam logic signed [ERR_W-1:0] TWO_PI_Q13 = 18'sd51472;
  localparam logic signed [CORDIC_W-1:0] HALF_PI_Q24 = 28'sd26353589;
  localparam logic signed [CORDIC_W-1:0] ROUND_Q24 = 28'sd1024;

  typedef enum logic [1:0] {
    OP_POSITION = 2'd0,
    OP_HEADING  = 2'd1,
    OP_WAYPOINT = 2'd2,
    OP_UNUSED   = 2'd3
  } op_e;

  typedef enum logic [2:0] {
    REG_TOLERANCE = 3'd0,
    REG_TURN_RATE = 3'd1,
    REG_FWD_SPEED = 3'd2,
    REG_HALF_WIDTH = 3'd3,
    REG_ROUTE_LEN = 3'd4
  } reg_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_INIT,
    ST_ITER,
    ST_ERR,
    ST_DECIDE,
    ST_OUT_STEER,
    ST_OUT_STOP
  } state_e;

  typedef struct packed {
    logic [14:0] tolerance;
    logic [14:0] turn_rate;
    logic [14:0] fwd_speed;
    logic [22:0] half_width;
    logic [7:0]  route_len;
  } cfg_t;

  typedef struct packed {
    logic              load_pos;
    logic              wr_wp;
    logic              start;
    logic              init;
    logic              iter;
    logic [ITER_W-1:0] iter_idx;
    logic              calc_err;
    logic              decide;
    logic              load_stop;
  } cmd_t;

  typedef struct packed {
    logic arrived;
  } status_t;

  // Arctangent of 2^-i in units of 2^-24 rad.
  function automatic logic signed [CORDIC_W-1:0] atan_q24(input logic [ITER_W-1:0] idx);
    logic signed [CORDIC_W-1:0] v;
    begin
      case (idx)
        5'd0:  v = 28'sd13176795;
        5'd1:  v = 28'sd7778716;
        5'd2:  v = 28'sd4110060;
        5'd3:  v = 28'sd2086331;
        5'd4:  v = 28'sd1047214;
        5'd5:  v = 28'sd524117;
        5'd6:  v = 28'sd262123;
        5'd7:  v = 28'sd131069;
        5'd8:  v = 28'sd65536;
        5'd9:  v = 28'sd32768;
        5'd10: v = 28'sd16384;
        5'd11: v = 28'sd8192;
        5'd12: v = 28'sd4096;
        5'd13: v = 28'sd2048;
        5'd14: v = 28'sd1024;
        5'd15: v = 28'sd512;
        5'd16: v = 28'sd256;
        5'd17: v = 28'sd128;
        5'd18: v = 28'sd64;
        5'd19: v = 28'sd32;
        5'd20: v = 28'sd16;
        5'd21: v = 28'sd8;
        5'd22: v = 28'sd4;
        5'd23: v = 28'sd2;
        default: v = '0;
      endcase
      return v;
    end
  endfunction

endpackage

>>> rtl/wphf_ram.sv
// ----------------------------------------------------------------------------
// wphf_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module wphf_ram #(
  parameter int unsigned WIDTH = 48,
  parameter int unsigned DEPTH = 128
) (
  input  logic                     clk_i,
  input  logic                     wr_en_i,
  input  logic [$clog2(DEPTH)-1:0] wr_addr_i,
  input  logic [WIDTH-1:0]         wr_data_i,
  input  logic                     rd_en_i,
  input  logic [$clog2(DEPTH)-1:0] rd_addr_i,
  output logic [WIDTH-1:0]         rd_data_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

>>> rtl/wphf_ctrl.sv
// ----------------------------------------------------------------------------
// wphf_ctrl
// Sequencer for one item: route read, CORDIC iterations, decision, results.
// ----------------------------------------------------------------------------
module wphf_ctrl #(
  parameter int unsigned ATAN_ITERATIONS = wphf_pkg::ATAN_ITERATIONS_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [1:0]        operation_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  input  wphf_pkg::status_t status_i,
  output wphf_pkg::cmd_t    cmd_o
);
  import wphf_pkg::*;

  state_e state_q, state_d;
  logic [ITER_W-1:0] cnt_q, cnt_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    in_ready_o  = 1'b0;
    out_valid_o = 1'b0;
    cmd_o       = '0;
    cmd_o.iter_idx = cnt_q;
    unique case (state_q)
      ST_IDLE: begin
        // Ready is always high here, so a valid beat is an accepted beat.
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          case (op_e'(operation_i))
            OP_POSITION: cmd_o.load_pos = 1'b1;
            OP_WAYPOINT: cmd_o.wr_wp = 1'b1;
            OP_HEADING: begin
              cmd_o.start = 1'b1;
              state_d = ST_INIT;
            end
            default: ;
          endcase
        end
      end
      ST_INIT: begin
        cmd_o.init = 1'b1;
        cnt_d = '0;
        state_d = ST_ITER;
      end
      ST_ITER: begin
        cmd_o.iter = 1'b1;
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == ITER_W'(ATAN_ITERATIONS - 1)) begin
          state_d = ST_ERR;
        end
      end
      ST_ERR: begin
        cmd_o.calc_err = 1'b1;
        state_d = ST_DECIDE;
      end
      ST_DECIDE: begin
        cmd_o.decide = 1'b1;
        state_d = ST_OUT_STEER;
      end
      ST_OUT_STEER: begin
        out_valid_o = 1'b1;
        if (out_ready_i) begin
          if (status_i.arrived) begin
            cmd_o.load_stop = 1'b1;
            state_d = ST_OUT_STOP;
          end else begin
            state_d = ST_IDLE;
          end
        end
      end
      ST_OUT_STOP: begin
        out_valid_o = 1'b1;
        if (out_ready_i) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

endmodule

>>> rtl/wphf_dp.sv
// ----------------------------------------------------------------------------
// wphf_dp
// Datapath: position and route storage, CORDIC atan2, error wrap, commands.
// ----------------------------------------------------------------------------
module wphf_dp #(
  parameter int unsigned MAX_WAYPOINTS = wphf_pkg::MAX_WAYPOINTS_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  wphf_pkg::cmd_t      cmd_i,
  output wphf_pkg::status_t   status_o,
  input  wphf_pkg::cfg_t      cfg_i,
  input  logic signed [23:0]  pos_x_i,
  input  logic signed [23:0]  pos_y_i,
  input  logic signed [15:0]  heading_i,
  input  logic [6:0]          waypoint_index_i,
  input  logic signed [23:0]  waypoint_x_i,
  input  logic signed [23:0]  waypoint_y_i,
  output logic [14:0]         linear_speed_o,
  output logic signed [15:0]  angular_speed_o,
  output logic                is_stop_o,
  output logic                route_done_o,
  output logic [7:0]          current_waypoint_o,
  output logic                last_o
);
  import wphf_pkg::*;

  localparam int unsigned AW = $clog2(MAX_WAYPOINTS);

  logic signed [COORD_W-1:0] px_q, py_q;
  logic signed [15:0] hd_q;
  logic [7:0] goal_q;
  logic done_q;
  logic signed [CORDIC_W-1:0] x_q, y_q, z_q;
  logic zero_q, arrived_q;
  logic signed [ERR_W-1:0] err_q;

  logic [7:0] len, slot;
  logic [2*COORD_W-1:0] rd_data;
  logic signed [COORD_W-1:0] wx, wy;
  logic wr_ok;

  // Clamp the route length into 1..MAX_WAYPOINTS.
  always_comb begin
    if (cfg_i.route_len == 8'd0) begin
      len = 8'd1;
    end else if (int'(cfg_i.route_len) > int'(MAX_WAYPOINTS)) begin
      len = 8'(MAX_WAYPOINTS);
    end else begin
      len = cfg_i.route_len;
    end
    slot = (goal_q < len) ? goal_q : len - 8'd1;
  end

  assign wr_ok = cmd_i.wr_wp && (int'(waypoint_index_i) < int'(MAX_WAYPOINTS));

  wphf_ram #(
    .WIDTH(2*COORD_W),
    .DEPTH(MAX_WAYPOINTS)
  ) u_route (
    .clk_i    (clk_i),
    .wr_en_i  (wr_ok),
    .wr_addr_i(AW'(waypoint_index_i)),
    .wr_data_i({waypoint_x_i, waypoint_y_i}),
    .rd_en_i  (cmd_i.start),
    .rd_addr_i(AW'(slot)),
    .rd_data_o(rd_data)
  );

  assign wx = $signed(rd_data[2*COORD_W-1:COORD_W]);
  assign wy = $signed(rd_data[COORD_W-1:0]);

  // Start values of the rotation and the arrival test.
  logic signed [24:0] dx, dy;
  logic signed [25:0] hw, wx_e, wy_e, px_e, py_e;
  logic arrived_d;
  assign dx = 25'(wx) - 25'(px_q);
  assign dy = 25'(wy) - 25'(py_q);
  assign hw = $signed({3'b000, cfg_i.half_width});
  assign wx_e = 26'(wx);
  assign wy_e = 26'(wy);
  assign px_e = 26'(px_q);
  assign py_e = 26'(py_q);
  assign arrived_d = (px_e > wx_e - hw) && (px_e < wx_e + hw) &&
                     (py_e > wy_e - hw) && (py_e < wy_e + hw);

  // One micro-rotation.
  logic signed [CORDIC_W-1:0] xs, ys, at;
  assign xs = x_q >>> cmd_i.iter_idx;
  assign ys = y_q >>> cmd_i.iter_idx;
  assign at = atan_q24(cmd_i.iter_idx);

  // Bearing error wrapped into plus or minus pi.
  logic signed [CORDIC_W-1:0] z_rnd;
  logic signed [16:0] bearing;
  logic signed [ERR_W-1:0] err_raw, err_wr;
  assign z_rnd = z_q + ROUND_Q24;
  assign bearing = zero_q ? 17'sd0 : $signed(z_rnd[27:11]);
  assign err_raw = ERR_W'(bearing) - ERR_W'(hd_q);
  always_comb begin
    if (err_raw > PI_Q13) begin
      err_wr = err_raw - TWO_PI_Q13;
    end else if (err_raw < -PI_Q13) begin
      err_wr = err_raw + TWO_PI_Q13;
    end else begin
      err_wr = err_raw;
    end
  end

  // Goal advance on arrival.
  logic [8:0] g_inc;
  logic [7:0] goal_d;
  logic done_d;
  logic signed [ERR_W-1:0] tol;
  assign g_inc = {1'b0, goal_q} + 9'd1;
  assign tol = $signed({3'b000, cfg_i.tolerance});
  always_comb begin
    goal_d = goal_q;
    done_d = done_q;
    if (arrived_q && !done_q) begin
      if (g_inc >= {1'b0, len}) begin
        done_d = 1'b1;
        goal_d = len;
      end else begin
        goal_d = g_inc[7:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      px_q   <= '0;
      py_q   <= '0;
      goal_q <= '0;
      done_q <= 1'b0;
    end else begin
      if (cmd_i.load_pos) begin
        px_q <= pos_x_i;
        py_q <= pos_y_i;
      end
      if (cmd_i.decide) begin
        goal_q <= goal_d;
        done_q <= done_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      hd_q <= heading_i;
    end
    if (cmd_i.init) begin
      zero_q    <= (dx == 25'sd0) && (dy == 25'sd0);
      arrived_q <= arrived_d;
      if (dx < 0) begin
        if (dy >= 0) begin
          z_q <= HALF_PI_Q24;
          x_q <= CORDIC_W'(dy);
          y_q <= -CORDIC_W'(dx);
        end else begin
          z_q <= -HALF_PI_Q24;
          x_q <= -CORDIC_W'(dy);
          y_q <= CORDIC_W'(dx);
        end
      end else begin
        z_q <= '0;
        x_q <= CORDIC_W'(dx);
        y_q <= CORDIC_W'(dy);
      end
    end else if (cmd_i.iter) begin
      if (y_q > 0) begin
        x_q <= x_q + ys;
        y_q <= y_q - xs;
        z_q <= z_q + at;
      end else begin
        x_q <= x_q - ys;
        y_q <= y_q + xs;
        z_q <= z_q - at;
      end
    end
    if (cmd_i.calc_err) begin
      err_q <= err_wr;
    end
    if (cmd_i.decide) begin
      is_stop_o          <= 1'b0;
      route_done_o       <= done_d;
      current_waypoint_o <= goal_d;
      last_o             <= !arrived_q;
      if (err_q > tol) begin
        linear_speed_o  <= '0;
        angular_speed_o <= $signed({1'b0, cfg_i.turn_rate});
      end else if (err_q < -tol) begin
        linear_speed_o  <= '0;
        angular_speed_o <= -$signed({1'b0, cfg_i.turn_rate});
      end else begin
        linear_speed_o  <= cfg_i.fwd_speed;
        angular_speed_o <= '0;
      end
    end else if (cmd_i.load_stop) begin
      linear_speed_o  <= '0;
      angular_speed_o <= '0;
      is_stop_o       <= 1'b1;
      last_o          <= 1'b1;
    end
  end

  assign status_o.arrived = arrived_q;

endmodule

>>> rtl/waypoint_heading_follower.sv
// ----------------------------------------------------------------------------
// waypoint_heading_follower
// Waypoint follower with bang-bang heading control and an APB register file.
// ----------------------------------------------------------------------------
// Position updates and waypoint writes produce no beat.
// A heading update shows its steering beat once it has passed the INIT, ITER,
// ERR and DECIDE states; ITER uses the one shared CORDIC stage that does one
// rotation per cycle; an arrival adds a stop beat right after it.
// One heading item occupies the block until its last beat is taken.
// Reset clears position, goal index and done flag and sets the registers to
// their defaults; the route table holds no defined value until written.
module waypoint_heading_follower #(
  parameter int unsigned MAX_WAYPOINTS   = wphf_pkg::MAX_WAYPOINTS_DEF,
  parameter int unsigned ATAN_ITERATIONS = wphf_pkg::ATAN_ITERATIONS_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [1:0]         operation_i,
  input  logic signed [23:0] pos_x_i,
  input  logic signed [23:0] pos_y_i,
  input  logic signed [15:0] heading_i,
  input  logic [6:0]         waypoint_index_i,
  input  logic signed [23:0] waypoint_x_i,
  input  logic signed [23:0] waypoint_y_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [14:0]        linear_speed_o,
  output logic signed [15:0] angular_speed_o,
  output logic               is_stop_o,
  output logic               route_done_o,
  output logic [7:0]         current_waypoint_o,
  output logic               last_o,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [4:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);
  import wphf_pkg::*;

  cfg_t cfg_q;
  cmd_t cmd;
  status_t status;
  logic cfg_we;

  // Registers are written in the access phase; pready never stalls.
  assign pready = 1'b1;
  assign cfg_we = psel & penable & pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.tolerance  <= 15'd164;
      cfg_q.turn_rate  <= 15'd410;
      cfg_q.fwd_speed  <= 15'd819;
      cfg_q.half_width <= 23'd13107;
      cfg_q.route_len  <= 8'd100;
    end else if (cfg_we) begin
      unique case (paddr[4:2])
        REG_TOLERANCE:  cfg_q.tolerance  <= pwdata[14:0];
        REG_TURN_RATE:  cfg_q.turn_rate  <= pwdata[14:0];
        REG_FWD_SPEED:  cfg_q.fwd_speed  <= pwdata[14:0];
        REG_HALF_WIDTH: cfg_q.half_width <= pwdata[22:0];
        REG_ROUTE_LEN:  cfg_q.route_len  <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  // Read-back of the register file; unmapped addresses read zero.
  always_comb begin
    unique case (paddr[4:2])
      REG_TOLERANCE:  prdata = {17'd0, cfg_q.tolerance};
      REG_TURN_RATE:  prdata = {17'd0, cfg_q.turn_rate};
      REG_FWD_SPEED:  prdata = {17'd0, cfg_q.fwd_speed};
      REG_HALF_WIDTH: prdata = {9'd0, cfg_q.half_width};
      REG_ROUTE_LEN:  prdata = {24'd0, cfg_q.route_len};
      default:        prdata = '0;
    endcase
  end

  // The sequencer steps the datapath through read, rotate, decide and send.
  wphf_ctrl #(
    .ATAN_ITERATIONS(ATAN_ITERATIONS)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .operation_i(operation_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  wphf_dp #(
    .MAX_WAYPOINTS(MAX_WAYPOINTS)
  ) u_dp (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cmd_i             (cmd),
    .status_o          (status),
    .cfg_i             (cfg_q),
    .pos_x_i           (pos_x_i),
    .pos_y_i           (pos_y_i),
    .heading_i         (heading_i),
    .waypoint_index_i  (waypoint_index_i),
    .waypoint_x_i      (waypoint_x_i),
    .waypoint_y_i      (waypoint_y_i),
    .linear_speed_o    (linear_speed_o),
    .angular_speed_o   (angular_speed_o),
    .is_stop_o         (is_stop_o),
    .route_done_o      (route_done_o),
    .current_waypoint_o(current_waypoint_o),
    .last_o            (last_o)
  );

endmodule
